>>> rtl/core/pal_pkg.sv
// Shared types and constants for the positional array list unit.
// Used by pal_ctrl, pal_dpath and positional_array_list_unit; no dependencies.
`default_nettype none

package pal_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int POS_W       = 6;
    localparam int LIM_W       = 6;
    localparam int KIND_W      = 2;
    localparam int ST_W        = 2;

    localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd3;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 6'd32;

    // Controller to datapath
    typedef struct packed {
        logic load_op;     // capture a new transaction
        logic decide;      // latch status
        logic rd_pos;      // read entry at position
        logic start_walk;  // set up the shift walk
        logic walk;        // advance the shift walk
        logic cap_rval;    // capture read data as result value
        logic wr_pos;      // write the new word at position
        logic cnt_inc;
        logic cnt_dec;
        logic res_load;    // load the output register
    } pal_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              ok;
        logic              walk_done;
    } pal_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/positional_array_list_unit.sv
// Positional array list unit: an ordered list of signed 32-bit words, 1-based.
// Top level; instantiates pal_ctrl and pal_dpath, uses pal_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries kind, position and write_value:
//   read, modify, insert (later entries move up) or remove (later entries
//   move down). Output channel (out_valid/out_ready) returns one result per
//   transaction: read_value, status, entry_count, is_empty, is_full.
//   Config channel (cfg_valid/cfg_ready, always ready) writes capacity_limit;
//   write it only while no transaction is in flight.
// Timing:
//   One transaction at a time. Insert moves the entries at and above the
//   position up and remove moves the entries above it down, one per cycle;
//   input is ready again in the same cycle that the result appears.
// Reset:
//   The list is empty and capacity_limit returns to 32; no clearing pass.
// Stall:
//   A result waits in the output register; the next transaction is accepted
//   and worked on, and holds before its result until the register is taken.
`default_nettype none

module positional_array_list_unit (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire [pal_pkg::KIND_W-1:0]         kind,
    input  wire [pal_pkg::POS_W-1:0]          position,
    input  wire signed [pal_pkg::DATA_W-1:0]  write_value,
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic signed [pal_pkg::DATA_W-1:0] read_value,
    output logic [pal_pkg::ST_W-1:0]          status,
    output logic [pal_pkg::CNT_W-1:0]         entry_count,
    output logic                              is_empty,
    output logic                              is_full,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire [pal_pkg::LIM_W-1:0]          capacity_limit
);

    pal_pkg::pal_cmd_t  cmd;
    pal_pkg::pal_stat_t stat;

    assign cfg_ready = 1'b1;

    pal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pal_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .kind           (kind),
        .position       (position),
        .write_value    (write_value),
        .cfg_valid      (cfg_valid),
        .capacity_limit (capacity_limit),
        .read_value     (read_value),
        .status         (status),
        .entry_count    (entry_count),
        .is_empty       (is_empty),
        .is_full        (is_full)
    );

endmodule

`default_nettype wire

>>> rtl/core/pal_dpath.sv
// Datapath of the positional array list: entry memory, count, limit, shift walk.
// Depends on pal_pkg.
`default_nettype none

module pal_dpath (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire pal_pkg::pal_cmd_t           cmd,
    output pal_pkg::pal_stat_t               stat,
    input  wire [pal_pkg::KIND_W-1:0]        kind,
    input  wire [pal_pkg::POS_W-1:0]         position,
    input  wire signed [pal_pkg::DATA_W-1:0] write_value,
    input  wire                              cfg_valid,
    input  wire [pal_pkg::LIM_W-1:0]         capacity_limit,
    output logic signed [pal_pkg::DATA_W-1:0] read_value,
    output logic [pal_pkg::ST_W-1:0]         status,
    output logic [pal_pkg::CNT_W-1:0]        entry_count,
    output logic                             is_empty,
    output logic                             is_full
);

    logic [pal_pkg::DATA_W-1:0] mem [pal_pkg::MAX_ENTRIES];

    logic [pal_pkg::KIND_W-1:0] op_kind_reg;
    logic [pal_pkg::POS_W-1:0]  op_pos_reg;
    logic [pal_pkg::DATA_W-1:0] op_wval_reg;
    logic [pal_pkg::CNT_W-1:0]  count_reg;
    logic [pal_pkg::LIM_W-1:0]  limit_reg;
    logic [pal_pkg::ST_W-1:0]   st_reg;
    logic [pal_pkg::DATA_W-1:0] rval_reg;
    logic [pal_pkg::DATA_W-1:0] rdata_reg;
    logic [pal_pkg::ADDR_W-1:0] src_reg;
    logic [pal_pkg::ADDR_W-1:0] dst_reg;
    logic [pal_pkg::CNT_W-1:0]  moves_reg;
    logic                       pend_reg;

    logic [pal_pkg::LIM_W-1:0]  lim;
    logic [pal_pkg::ST_W-1:0]   st_next;
    logic [pal_pkg::ADDR_W-1:0] pos_m1;
    logic [pal_pkg::ADDR_W-1:0] rd_addr;
    logic                       is_ins;
    logic                       issue;
    logic                       wr_en;
    logic [pal_pkg::ADDR_W-1:0] wr_addr;
    logic [pal_pkg::DATA_W-1:0] wr_data;
    logic [pal_pkg::POS_W:0]    pos_x;
    logic [pal_pkg::POS_W:0]    cnt_x;

    always_comb
    begin
        if (limit_reg > pal_pkg::LIM_W'(pal_pkg::MAX_ENTRIES))
            lim = pal_pkg::LIM_W'(pal_pkg::MAX_ENTRIES);
        else
            lim = limit_reg;
    end

    assign pos_x  = {1'b0, op_pos_reg};
    assign cnt_x  = (pal_pkg::POS_W + 1)'(count_reg);
    assign pos_m1 = pal_pkg::ADDR_W'(op_pos_reg - 1'b1);
    assign is_ins = (op_kind_reg == pal_pkg::KIND_INSERT);

    always_comb
    begin
        st_next = pal_pkg::ST_OK;
        if (is_ins)
        begin
            if ((pal_pkg::POS_W + 1)'(count_reg) >= (pal_pkg::POS_W + 1)'(lim))
                st_next = pal_pkg::ST_FULL;
            else if (op_pos_reg == '0 || pos_x > cnt_x + 1'b1)
                st_next = pal_pkg::ST_BAD_POS;
        end
        else if (op_pos_reg == '0 || pos_x > cnt_x)
            st_next = pal_pkg::ST_BAD_POS;
    end

    assign stat.kind      = op_kind_reg;
    assign stat.ok        = (st_next == pal_pkg::ST_OK);
    assign stat.walk_done = (moves_reg == '0) && !pend_reg;

    // Walk issues one read per cycle and writes the previous read one slot over
    assign issue   = cmd.walk && (moves_reg != '0);
    assign rd_addr = cmd.rd_pos ? pos_m1 : src_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = dst_reg;
        wr_data = rdata_reg;
        if (cmd.wr_pos)
        begin
            wr_en   = 1'b1;
            wr_addr = pos_m1;
            wr_data = op_wval_reg;
        end
        else if (cmd.walk && pend_reg)
            wr_en = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[rd_addr];
    end

    // Operand and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_op)
        begin
            op_kind_reg <= kind;
            op_pos_reg  <= position;
            op_wval_reg <= write_value;
            rval_reg    <= '0;
        end
        if (cmd.decide)
            st_reg <= st_next;
        if (cmd.cap_rval)
            rval_reg <= rdata_reg;
        if (cmd.start_walk)
        begin
            if (is_ins)
                src_reg <= pal_pkg::ADDR_W'(count_reg - 1'b1);
            else
                src_reg <= pal_pkg::ADDR_W'(op_pos_reg);
        end
        else if (issue)
        begin
            src_reg <= is_ins ? src_reg - 1'b1 : src_reg + 1'b1;
            dst_reg <= is_ins ? src_reg + 1'b1 : src_reg - 1'b1;
        end
        if (cmd.res_load)
        begin
            read_value  <= rval_reg;
            status      <= st_reg;
            entry_count <= count_reg;
            is_empty    <= (count_reg == '0);
            is_full     <= ((pal_pkg::POS_W + 1)'(count_reg)
                            >= (pal_pkg::POS_W + 1)'(lim));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            limit_reg <= pal_pkg::LIMIT_RESET;
            pend_reg  <= 1'b0;
            moves_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
                limit_reg <= capacity_limit;
            if (cmd.cnt_inc)
                count_reg <= count_reg + 1'b1;
            else if (cmd.cnt_dec)
                count_reg <= count_reg - 1'b1;
            if (cmd.start_walk)
                pend_reg <= 1'b0;
            else if (cmd.walk)
                pend_reg <= issue;
            if (cmd.start_walk)
            begin
                if (is_ins)
                    moves_reg <= pal_pkg::CNT_W'(cnt_x - pos_x + 1'b1);
                else
                    moves_reg <= pal_pkg::CNT_W'(cnt_x - pos_x);
            end
            else if (issue)
                moves_reg <= moves_reg - 1'b1;
        end
    end

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |->
            (count_reg == $past(count_reg) + 1'b1 || count_reg == $past(count_reg) - 1'b1))
        else $error("entry count moved by more than one");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> st_reg == pal_pkg::ST_OK && is_ins && count_reg < lim)
        else $error("count raised on a refused insert");

    a_write_conflict: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_pos |-> !pend_reg && moves_reg == '0)
        else $error("position write collides with shift walk");

    a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> moves_reg == '0 && !pend_reg)
        else $error("result loaded before shift walk finished");

endmodule

`default_nettype wire

>>> rtl/core/pal_ctrl.sv
// Controller of the positional array list: sequences one transaction at a time.
// Depends on pal_pkg; drives pal_dpath through pal_cmd_t.
`default_nettype none

module pal_ctrl (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire                    out_ready,
    input  wire pal_pkg::pal_stat_t stat,
    output pal_pkg::pal_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_RD_CAP = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_op = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (!stat.ok)
                    state_next = S_FINISH;
                else
                begin
                    case (stat.kind)
                        pal_pkg::KIND_READ:
                        begin
                            cmd.rd_pos = 1'b1;
                            state_next = S_RD_CAP;
                        end
                        pal_pkg::KIND_MODIFY:
                        begin
                            cmd.wr_pos = 1'b1;
                            state_next = S_FINISH;
                        end
                        pal_pkg::KIND_INSERT:
                        begin
                            cmd.start_walk = 1'b1;
                            state_next     = S_WALK;
                        end
                        pal_pkg::KIND_REMOVE:
                        begin
                            cmd.rd_pos     = 1'b1;
                            cmd.start_walk = 1'b1;
                            state_next     = S_RD_CAP;
                        end
                        default:
                            state_next = S_FINISH;
                    endcase
                end
            end
            S_RD_CAP:
            begin
                cmd.cap_rval = 1'b1;
                state_next   = (stat.kind == pal_pkg::KIND_REMOVE) ? S_WALK : S_FINISH;
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_done)
                begin
                    // place the new word once every entry above it has moved
                    if (stat.kind == pal_pkg::KIND_INSERT)
                    begin
                        cmd.wr_pos  = 1'b1;
                        cmd.cnt_inc = 1'b1;
                    end
                    else
                        cmd.cnt_dec = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_decides: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_DECIDE)
        else $error("accepted transaction not evaluated");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> !out_valid_reg || out_ready)
        else $error("result register overwritten before it was taken");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |=> out_valid_reg && state_reg == S_IDLE)
        else $error("loaded result not presented");

endmodule

`default_nettype wire
